/* design/gps_channel_allocator_core_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the GPS channel allocator
// Concurrent checks that are compiled for simulation and left out for synthesis.
// ---------------------------------------------------------------------------
`ifndef GPS_CHANNEL_ALLOCATOR_CORE_DEFINES_SVH
`define GPS_CHANNEL_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checks a condition at every clock edge outside reset.
`define GCA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gca: assertion failed");
// Checks that a condition in one cycle is followed by another in the next.
`define GCA_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("gca: assertion failed");
`else
`define GCA_ASSERT(lbl, clk, rst_n, prop)
`define GCA_ASSERT_NEXT(lbl, clk, rst_n, cond, prop)
`endif

`endif

/* design/gca_pkg.sv */
// ---------------------------------------------------------------------------
// GPS channel allocator package
// Widths, codes, result types and satellite tables shared by the modules.
// ---------------------------------------------------------------------------
package gca_pkg;

    localparam int NUM_CHANNELS_DEF = 12;
    localparam int CH_SLOTS         = 16;
    localparam int MASK_W           = 12;
    localparam int CHAN_W           = 4;
    localparam int SAT_W            = 6;
    localparam int TIME_W           = 20;
    localparam int WIN_W            = 16;
    localparam int CW_W             = 16;
    localparam int TRY_W            = 5;
    localparam int WEEK_SECONDS     = 604800;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd1200;
    localparam logic [CW_W-1:0]  CTRL_BITS    = 16'hA000;
    localparam logic [TRY_W-1:0] LAST_TRY     = 5'd31;

    localparam logic [SAT_W-1:0] SAT_FIRST  = 6'd1;
    localparam logic [SAT_W-1:0] SAT_LAST   = 6'd32;
    localparam logic [SAT_W-1:0] SAT_SKIP_A = 6'd12;
    localparam logic [SAT_W-1:0] SAT_SKIP_B = 6'd17;
    localparam logic [SAT_W-1:0] SAT_SKIP_C = 6'd31;
    localparam logic [SAT_W-1:0] SAT_SKIP_D = 6'd32;

    typedef enum logic {
        OP_LOCK  = 1'b0,
        OP_ALLOC = 1'b1
    } t_op;

    typedef enum logic {
        ACT_RESTART = 1'b0,
        ACT_ASSIGN  = 1'b1
    } t_action;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [SAT_W-1:0]  sat;
        t_action           action;
        logic [CW_W-1:0]   control_word;
    } t_result;

    typedef struct packed {
        logic push;
        logic flush;
    } t_stage_req;

    typedef struct packed {
        logic ready;
        logic pend_valid;
    } t_stage_sts;

    // Satellite held by each channel after reset.
    function automatic logic [SAT_W-1:0] sat_reset(input logic [CHAN_W-1:0] ch);
        logic [SAT_W-1:0] s;
        case (ch)
            4'd0:    s = 6'd6;
            4'd1:    s = 6'd8;
            4'd2:    s = 6'd9;
            4'd3:    s = 6'd10;
            4'd4:    s = 6'd13;
            4'd5:    s = 6'd14;
            4'd6:    s = 6'd16;
            4'd7:    s = 6'd19;
            4'd8:    s = 6'd20;
            4'd9:    s = 6'd21;
            4'd10:   s = 6'd24;
            4'd11:   s = 6'd28;
            4'd12:   s = 6'd1;
            4'd13:   s = 6'd2;
            4'd14:   s = 6'd3;
            default: s = 6'd4;
        endcase
        return s;
    endfunction

    // Code generator tap word for a satellite, with the control bits set.
    function automatic logic [CW_W-1:0] control_for(input logic [SAT_W-1:0] sat);
        logic [9:0] t;
        case (sat)
            6'd1:    t = 10'h3f6;
            6'd2:    t = 10'h3ec;
            6'd3:    t = 10'h3d8;
            6'd4:    t = 10'h3b0;
            6'd5:    t = 10'h04b;
            6'd6:    t = 10'h096;
            6'd7:    t = 10'h2cb;
            6'd8:    t = 10'h196;
            6'd9:    t = 10'h32c;
            6'd10:   t = 10'h3ba;
            6'd11:   t = 10'h374;
            6'd12:   t = 10'h1d0;
            6'd13:   t = 10'h3a0;
            6'd14:   t = 10'h340;
            6'd15:   t = 10'h280;
            6'd16:   t = 10'h100;
            6'd17:   t = 10'h113;
            6'd18:   t = 10'h226;
            6'd19:   t = 10'h04c;
            6'd20:   t = 10'h098;
            6'd21:   t = 10'h130;
            6'd22:   t = 10'h260;
            6'd23:   t = 10'h267;
            6'd24:   t = 10'h338;
            6'd25:   t = 10'h270;
            6'd26:   t = 10'h0e0;
            6'd27:   t = 10'h1c0;
            6'd28:   t = 10'h380;
            6'd29:   t = 10'h22b;
            6'd30:   t = 10'h056;
            6'd31:   t = 10'h0ac;
            6'd32:   t = 10'h158;
            default: t = 10'h000;
        endcase
        return {6'b0, t} | CTRL_BITS;
    endfunction

    // One round-robin step over the satellites, passing over the skipped ones.
    function automatic logic [SAT_W-1:0] step_pointer(input logic [SAT_W-1:0] p);
        logic [SAT_W-1:0] nxt;
        nxt = p + 6'd1;
        if (p >= SAT_SKIP_C - 6'd1) begin
            nxt = SAT_FIRST;
        end else if (nxt == SAT_SKIP_A || nxt == SAT_SKIP_B) begin
            nxt = nxt + 6'd1;
        end
        return nxt;
    endfunction

endpackage

/* design/gps_channel_allocator_core.sv */
// ---------------------------------------------------------------------------
// GPS channel allocator core
// Assigns satellites to receiver channels and issues their control words.
// ---------------------------------------------------------------------------
// A lock notice, taken while idle, writes the channel's lock time straight
// into the lock-time memory. An allocation pass is worked through by a
// sequencer over the satellite and lock-time memories: the first walk reads
// each channel, then evaluates it and writes back; the second walk checks
// each channel and, for each channel still off, searches at most 32
// round-robin steps over an occupancy map of the satellites. Each result is
// passed on to the result stage in a step of its own, and the pass closes
// with a step that marks the final result; a wait on the output side can
// hold either step.
// The next transfer is taken once the pass is closed.
module gps_channel_allocator_core #(
    parameter int NUM_CHANNELS = gca_pkg::NUM_CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gca_pkg::WIN_W-1:0]   i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_op,
    input  logic [gca_pkg::CHAN_W-1:0]  i_channel,
    input  logic [gca_pkg::TIME_W-1:0]  i_now_seconds,
    input  logic                        i_clock_valid,
    input  logic [gca_pkg::MASK_W-1:0]  i_off_mask,
    input  logic [gca_pkg::MASK_W-1:0]  i_lock_mask,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [gca_pkg::CHAN_W-1:0]  o_out_channel,
    output logic [gca_pkg::SAT_W-1:0]   o_sat_number,
    output logic                        o_action,
    output logic [gca_pkg::CW_W-1:0]    o_control_word,
    output logic                        o_last
);

    import gca_pkg::*;

`include "gps_channel_allocator_core_defines.svh"

    t_stage_req stage_req;
    t_stage_sts stage_sts;
    t_result    seq_res;

    gca_seq #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_channel     (i_channel),
        .i_now_seconds (i_now_seconds),
        .i_clock_valid (i_clock_valid),
        .i_off_mask    (i_off_mask),
        .i_lock_mask   (i_lock_mask),
        .o_req         (stage_req),
        .o_res         (seq_res),
        .i_sts         (stage_sts)
    );

    gca_out_stage u_out_stage (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (stage_req),
        .i_res          (seq_res),
        .o_sts          (stage_sts),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_out_channel  (o_out_channel),
        .o_sat_number   (o_sat_number),
        .o_action       (o_action),
        .o_control_word (o_control_word),
        .o_last         (o_last)
    );

    // Every satellite handed out lies within the numbering.
    `GCA_ASSERT(a_sat_range, i_clk, i_rst_n, !o_valid || (o_sat_number >= SAT_FIRST && o_sat_number <= SAT_LAST))

    // A fresh assignment never lands on a skipped satellite.
    `GCA_ASSERT(a_assign_not_skipped, i_clk, i_rst_n, !(o_valid && o_action) || (o_sat_number != SAT_SKIP_A && o_sat_number != SAT_SKIP_B && o_sat_number != SAT_SKIP_C && o_sat_number != SAT_SKIP_D))

    // When a new transfer can be taken, no result of the last pass is held back.
    `GCA_ASSERT(a_idle_no_pending, i_clk, i_rst_n, !o_ready || !stage_sts.pend_valid)

    // A result that was held back is released in the cycle the stage reports it.
    `GCA_ASSERT_NEXT(a_flush_closes, i_clk, i_rst_n, stage_req.flush && stage_sts.ready, !stage_sts.pend_valid && o_ready)

endmodule

/* design/gca_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with the read data registered.
// ---------------------------------------------------------------------------
module gca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/gca_out_stage.sv */
// ---------------------------------------------------------------------------
// GPS channel allocator result stage
// Holds one result back until the next one or the end of the pass marks it.
// ---------------------------------------------------------------------------
module gca_out_stage (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gca_pkg::t_stage_req       i_req,
    input  gca_pkg::t_result          i_res,
    output gca_pkg::t_stage_sts       o_sts,
    input  logic                      i_ready,
    output logic                      o_valid,
    output logic [gca_pkg::CHAN_W-1:0] o_out_channel,
    output logic [gca_pkg::SAT_W-1:0]  o_sat_number,
    output logic                      o_action,
    output logic [gca_pkg::CW_W-1:0]   o_control_word,
    output logic                      o_last
);

    import gca_pkg::*;

    t_result r_pend;
    logic    r_pend_valid;
    t_result r_out;
    logic    r_out_last;
    logic    r_out_valid;
    logic    out_free;
    logic    stage_ready;

    assign out_free    = !r_out_valid || i_ready;
    assign stage_ready = !r_pend_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_req.push && stage_ready) begin
                // A newer result means the held one is not the last of the pass.
                if (r_pend_valid) begin
                    r_out       <= r_pend;
                    r_out_last  <= 1'b0;
                    r_out_valid <= 1'b1;
                end else if (r_out_valid && i_ready) begin
                    r_out_valid <= 1'b0;
                end
                r_pend       <= i_res;
                r_pend_valid <= 1'b1;
            end else if (i_req.flush && stage_ready && r_pend_valid) begin
                r_out        <= r_pend;
                r_out_last   <= 1'b1;
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.ready      = stage_ready;
    assign o_sts.pend_valid = r_pend_valid;

    assign o_valid        = r_out_valid;
    assign o_out_channel  = r_out.channel;
    assign o_sat_number   = r_out.sat;
    assign o_action       = r_out.action;
    assign o_control_word = r_out.control_word;
    assign o_last         = r_out_last;

endmodule

/* design/gca_seq.sv */
// ---------------------------------------------------------------------------
// GPS channel allocator sequencer
// Writes lock notices and walks the channel memories for allocation passes.
// ---------------------------------------------------------------------------
module gca_seq #(
    parameter int NUM_CHANNELS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gca_pkg::WIN_W-1:0]   i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_op,
    input  logic [gca_pkg::CHAN_W-1:0]  i_channel,
    input  logic [gca_pkg::TIME_W-1:0]  i_now_seconds,
    input  logic                        i_clock_valid,
    input  logic [gca_pkg::MASK_W-1:0]  i_off_mask,
    input  logic [gca_pkg::MASK_W-1:0]  i_lock_mask,
    output gca_pkg::t_stage_req         o_req,
    output gca_pkg::t_result            o_res,
    input  gca_pkg::t_stage_sts         i_sts
);

    import gca_pkg::*;

    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int MAP_N = 2 ** SAT_W;
    localparam int DW    = TIME_W + 2;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_W1_RD  = 7'b0000010,
        S_W1_EV  = 7'b0000100,
        S_EMIT   = 7'b0001000,
        S_W2_CHK = 7'b0010000,
        S_SRCH   = 7'b0100000,
        S_FLUSH  = 7'b1000000
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_ch;
    logic                    r_phase2;
    logic [TIME_W-1:0]       r_now;
    logic                    r_cv;
    logic [CH_SLOTS-1:0]     r_lock;
    logic [NUM_CHANNELS-1:0] r_off;
    logic [MAP_N-1:0]        r_map;
    logic [SAT_W-1:0]        r_ptr;
    logic [SAT_W-1:0]        r_p;
    logic [TRY_W-1:0]        r_tries;
    t_result                 r_res;
    logic [WIN_W-1:0]        r_window;
    logic [NUM_CHANNELS-1:0] r_sat_vld;
    logic [NUM_CHANNELS-1:0] r_time_vld;

    logic [IDX_W-1:0]        idx;
    logic [CHAN_W-1:0]       ch4;
    logic                    last_ch;
    logic                    accept;
    logic [CH_SLOTS-1:0]     off_pad;

    logic [SAT_W-1:0]        sat_rdata;
    logic [TIME_W-1:0]       time_rdata;
    logic [SAT_W-1:0]        sat_cur;
    logic [TIME_W-1:0]       lt_cur;
    logic signed [DW-1:0]    diff;
    logic signed [DW-1:0]    diff_w;
    logic                    in_window;
    logic                    stamp;
    logic                    restart;
    logic                    off_new;

    logic [SAT_W-1:0]        p_next;
    logic                    found;

    logic                    notice_we;
    logic                    time_we;
    logic [IDX_W-1:0]        time_waddr;
    logic [TIME_W-1:0]       time_wdata;
    logic                    sat_we;

    assign idx     = r_ch[IDX_W-1:0];
    assign ch4     = CHAN_W'(r_ch);
    assign last_ch = (r_ch == CNT_W'(NUM_CHANNELS - 1));
    assign accept  = i_valid && o_ready;
    assign off_pad = {{(CH_SLOTS - MASK_W){1'b0}}, i_off_mask};

    // Entries never written read as their reset values.
    assign sat_cur = r_sat_vld[idx] ? sat_rdata : sat_reset(ch4);
    assign lt_cur  = r_time_vld[idx] ? time_rdata : '0;

    // Elapsed time since the last lock, wrapped over the week boundary.
    assign diff      = $signed({2'b00, r_now}) - $signed({2'b00, lt_cur});
    assign diff_w    = diff[DW-1] ? (diff + DW'(WEEK_SECONDS)) : diff;
    assign in_window = diff_w < $signed({{(DW - WIN_W){1'b0}}, r_window});

    assign stamp   = r_lock[ch4] && r_cv;
    assign restart = !stamp && r_off[idx] && in_window;
    assign off_new = r_off[idx] && !restart;

    assign p_next = step_pointer(r_p);
    assign found  = !r_map[p_next] || (r_tries == LAST_TRY);

    assign notice_we  = (r_state == S_IDLE) && i_valid && (t_op'(i_op) == OP_LOCK)
                        && i_clock_valid
                        && ({1'b0, i_channel} < (CHAN_W + 1)'(NUM_CHANNELS));
    assign time_we    = notice_we || ((r_state == S_W1_EV) && stamp);
    assign time_waddr = notice_we ? i_channel[IDX_W-1:0] : idx;
    assign time_wdata = notice_we ? i_now_seconds : r_now;
    assign sat_we     = (r_state == S_SRCH) && found;

    gca_ram #(
        .WIDTH (SAT_W),
        .DEPTH (NUM_CHANNELS)
    ) u_sat_ram (
        .i_clk   (i_clk),
        .i_we    (sat_we),
        .i_waddr (idx),
        .i_wdata (p_next),
        .i_raddr (idx),
        .o_rdata (sat_rdata)
    );

    gca_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NUM_CHANNELS)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (time_we),
        .i_waddr (time_waddr),
        .i_wdata (time_wdata),
        .i_raddr (idx),
        .o_rdata (time_rdata)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_req.push  = (r_state == S_EMIT);
    assign o_req.flush = (r_state == S_FLUSH);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ptr      <= '0;
            r_window   <= WINDOW_RESET;
            r_sat_vld  <= '0;
            r_time_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (time_we) begin
                r_time_vld[time_waddr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_now  <= i_now_seconds;
                        r_cv   <= i_clock_valid;
                        r_lock <= {{(CH_SLOTS - MASK_W){1'b0}}, i_lock_mask};
                        if (t_op'(i_op) == OP_ALLOC) begin
                            r_ch     <= '0;
                            r_phase2 <= 1'b0;
                            r_off    <= off_pad[NUM_CHANNELS-1:0];
                            r_map    <= '0;
                            r_state  <= S_W1_RD;
                        end
                    end
                end
                S_W1_RD: begin
                    r_state <= S_W1_EV;
                end
                S_W1_EV: begin
                    // Channels that stay on mark their satellite as taken.
                    if (!off_new) begin
                        r_map[sat_cur] <= 1'b1;
                    end
                    if (restart) begin
                        r_off[idx] <= 1'b0;
                        r_res      <= '{channel: ch4, sat: sat_cur, action: ACT_RESTART,
                                        control_word: control_for(sat_cur)};
                        r_state    <= S_EMIT;
                    end else if (last_ch) begin
                        r_ch     <= '0;
                        r_phase2 <= 1'b1;
                        r_state  <= S_W2_CHK;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_W1_RD;
                    end
                end
                S_EMIT: begin
                    if (i_sts.ready) begin
                        if (!r_phase2) begin
                            if (last_ch) begin
                                r_ch     <= '0;
                                r_phase2 <= 1'b1;
                                r_state  <= S_W2_CHK;
                            end else begin
                                r_ch    <= r_ch + 1'b1;
                                r_state <= S_W1_RD;
                            end
                        end else if (last_ch) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_W2_CHK;
                        end
                    end
                end
                S_W2_CHK: begin
                    if (r_off[idx]) begin
                        r_p     <= r_ptr;
                        r_tries <= '0;
                        r_state <= S_SRCH;
                    end else if (last_ch) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_ch <= r_ch + 1'b1;
                    end
                end
                S_SRCH: begin
                    if (found) begin
                        r_sat_vld[idx] <= 1'b1;
                        r_map[p_next]  <= 1'b1;
                        r_off[idx]     <= 1'b0;
                        r_ptr          <= p_next;
                        r_res          <= '{channel: ch4, sat: p_next, action: ACT_ASSIGN,
                                            control_word: control_for(p_next)};
                        r_state        <= S_EMIT;
                    end else begin
                        r_p     <= p_next;
                        r_tries <= r_tries + 1'b1;
                    end
                end
                S_FLUSH: begin
                    if (i_sts.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
